// File: design/pbm_pkg.sv
package pbm_pkg;

    // table geometry
    localparam int TABLE_ENTRIES  = 64;
    localparam int ENTRY_W        = 6;
    localparam int PAGE_OFS_W     = 10;
    localparam int ADDR_W         = 16;
    localparam int PHYS_W         = 18;
    localparam int CFG_W          = 64;

    // default virtual memory size in KB and pages in one 64 KB bank
    localparam int VIRTUAL_KB_DEF = 256;
    localparam int BANK_PAGES     = 64;

    // bank field and start frame widths
    localparam int BANK_W         = 5;
    localparam int BANK_CMP_W     = 6;
    localparam int BANK_FRAME_W   = 11;
    localparam int HALF_PAGE_W    = 5;

    // paging port bit positions
    localparam int PORT_UPPER_BIT = 0;
    localparam int PORT_BANK_LSB  = 1;
    localparam int PORT_BANK_MSB  = 5;
    localparam int PORT_LOWFIX_BIT = 6;
    localparam int PORT_MODE32_BIT = 7;

    // command codes
    localparam logic [1:0] CMD_PORT_WRITE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP      = 2'd1;
    localparam logic [1:0] CMD_RESET_PAGES = 2'd2;

    // configuration register indexes
    localparam logic CFG_LOCK_MASK = 1'b0;
    localparam logic CFG_ROM_MASK  = 1'b1;

    // table write strobe from the sequencer
    typedef struct packed {
        logic               frame_we;
        logic               unav_we;
        logic [ENTRY_W-1:0] entry;
        logic               unav;
    } t_tbl_wr;

    // sequencer status toward the output stage
    typedef struct packed {
        logic              ready;
        logic              res_load;
        logic [ADDR_W-1:0] addr;
    } t_ctrl_sts;

endpackage

// File: design/pbm_table.sv
module pbm_table #(
    parameter int FRAME_W = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbm_pkg::t_tbl_wr              i_wr,
    input  logic [FRAME_W-1:0]            i_wr_frame,
    input  logic                          i_rd_en,
    input  logic [pbm_pkg::ENTRY_W-1:0]   i_rd_entry,
    output logic [FRAME_W-1:0]            o_rd_frame,
    output logic                          o_rd_unav
);
    import pbm_pkg::*;

    // active frame and unavailable flag memories
    logic [FRAME_W-1:0] r_frame_mem [TABLE_ENTRIES];
    logic               r_unav_mem  [TABLE_ENTRIES];

    // written flags: an unwritten entry reads as the identity mapping
    logic [TABLE_ENTRIES-1:0] r_frame_vld;
    logic [TABLE_ENTRIES-1:0] r_unav_vld;

    // registered read side
    logic [FRAME_W-1:0] r_rd_frame;
    logic               r_rd_unav;
    logic               r_rd_fvld;
    logic               r_rd_uvld;
    logic [ENTRY_W-1:0] r_rd_entry;

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_wr.frame_we) begin
            r_frame_mem[i_wr.entry] <= i_wr_frame;
        end
        if (i_wr.unav_we) begin
            r_unav_mem[i_wr.entry] <= i_wr.unav;
        end
    end

    // written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_vld <= '0;
            r_unav_vld  <= '0;
        end else begin
            if (i_wr.frame_we) begin
                r_frame_vld[i_wr.entry] <= 1'b1;
            end
            if (i_wr.unav_we) begin
                r_unav_vld[i_wr.entry] <= 1'b1;
            end
        end
    end

    // memory reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_frame <= r_frame_mem[i_rd_entry];
            r_rd_unav  <= r_unav_mem[i_rd_entry];
            r_rd_fvld  <= r_frame_vld[i_rd_entry];
            r_rd_uvld  <= r_unav_vld[i_rd_entry];
            r_rd_entry <= i_rd_entry;
        end
    end

    // unwritten entries fall back to frame = index, available
    assign o_rd_frame = r_rd_fvld ? r_rd_frame : FRAME_W'(r_rd_entry);
    assign o_rd_unav  = r_rd_uvld & r_rd_unav;

endmodule

// File: design/pbm_ctrl.sv
module pbm_ctrl #(
    parameter int VIRTUAL_KB = pbm_pkg::VIRTUAL_KB_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [1:0]                         i_command,
    input  logic [7:0]                         i_port_value,
    input  logic [pbm_pkg::ADDR_W-1:0]         i_cpu_address,
    input  logic [pbm_pkg::TABLE_ENTRIES-1:0]  i_lock_mask,
    input  logic                               i_out_free,
    output pbm_pkg::t_ctrl_sts                 o_sts,
    output pbm_pkg::t_tbl_wr                   o_wr,
    output logic [$clog2(VIRTUAL_KB)-1:0]      o_wr_frame,
    output logic                               o_rd_en,
    output logic [pbm_pkg::ENTRY_W-1:0]        o_rd_entry
);
    import pbm_pkg::*;

    localparam int FRAME_W   = $clog2(VIRTUAL_KB);
    localparam int NUM_BANKS = VIRTUAL_KB / BANK_PAGES;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_RESULT = 3'b100
    } t_state;

    t_state             r_state,   n_state;
    logic [ENTRY_W-1:0] r_idx,     n_idx;
    logic [ENTRY_W-1:0] r_last,    n_last;
    logic [FRAME_W-1:0] r_frame,   n_frame;
    logic               r_unav,    n_unav;
    logic               r_restore, n_restore;
    logic [ADDR_W-1:0]  r_addr,    n_addr;

    logic                   accept;
    logic [BANK_W-1:0]      bank;
    logic                   bank_past;
    logic                   mode32;
    logic [BANK_FRAME_W-1:0] start_frame;
    logic                   entry_locked;

    // decode of the paging port word
    assign bank        = i_port_value[PORT_BANK_MSB:PORT_BANK_LSB];
    assign bank_past   = {1'b0, bank} >= BANK_CMP_W'(NUM_BANKS);
    assign mode32      = i_port_value[PORT_MODE32_BIT];
    assign start_frame = {bank, mode32 & i_port_value[PORT_UPPER_BIT],
                          {HALF_PAGE_W{1'b0}}};

    assign accept       = i_valid && (r_state == ST_IDLE);
    assign entry_locked = i_lock_mask[r_idx];

    // next-state logic and frame incrementer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_last    = r_last;
        n_frame   = r_frame;
        n_unav    = r_unav;
        n_restore = r_restore;
        n_addr    = r_addr;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_PORT_WRITE: begin
                            n_state   = ST_WALK;
                            n_restore = 1'b0;
                            n_unav    = bank_past;
                            n_frame   = FRAME_W'(start_frame);
                            if (mode32) begin
                                n_idx  = i_port_value[PORT_LOWFIX_BIT] ? ENTRY_W'(0)
                                                                       : ENTRY_W'(32);
                                n_last = i_port_value[PORT_LOWFIX_BIT] ? ENTRY_W'(31)
                                                                       : ENTRY_W'(63);
                            end else begin
                                n_idx  = '0;
                                n_last = '1;
                            end
                        end
                        CMD_RESET_PAGES: begin
                            n_state   = ST_WALK;
                            n_restore = 1'b1;
                            n_idx     = '0;
                            n_last    = '1;
                        end
                        CMD_LOOKUP: begin
                            n_state = ST_RESULT;
                            n_addr  = i_cpu_address;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                n_idx   = r_idx + ENTRY_W'(1);
                n_frame = r_frame + FRAME_W'(1);
                if (r_idx == r_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // walk and lookup registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_last    <= n_last;
        r_frame   <= n_frame;
        r_unav    <= n_unav;
        r_restore <= n_restore;
        r_addr    <= n_addr;
    end

    // table write for the current entry of the walk
    always_comb begin
        o_wr.entry    = r_idx;
        o_wr.unav     = r_unav;
        o_wr.frame_we = (r_state == ST_WALK) && !entry_locked;
        o_wr.unav_we  = (r_state == ST_WALK) && !entry_locked && !r_restore;
        if (r_restore) begin
            o_wr_frame = FRAME_W'(r_idx);
        end else if (r_unav) begin
            o_wr_frame = '0;
        end else begin
            o_wr_frame = r_frame;
        end
    end

    // lookup read is issued in the accept cycle
    assign o_rd_en    = accept && (i_command == CMD_LOOKUP);
    assign o_rd_entry = i_cpu_address[ADDR_W-1:PAGE_OFS_W];

    assign o_sts.ready    = (r_state == ST_IDLE);
    assign o_sts.res_load = (r_state == ST_RESULT) && i_out_free;
    assign o_sts.addr     = r_addr;

endmodule

// File: design/paged_ram_bank_mapper.sv
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_command, i_port_value, i_cpu_address
// result    out        o_valid / i_stall   o_physical_address, o_unavailable,
//                                          o_locked, o_write_protect
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// a port write walks 32 table entries in 32 KB mode and all 64 in 64 KB mode, reset pages all 64:
// the sequencer walks one table entry per cycle through the single table write port
// a lookup goes through the registered table read and then the output register, and can be held by an output stall
// synchronous active-low reset; table contents read as the identity map after reset,
// tracked by per-entry written flags, so no clearing pass is needed
// a word waiting in the output register does not block the next input word
module paged_ram_bank_mapper #(
    parameter int VIRTUAL_KB = pbm_pkg::VIRTUAL_KB_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_command,
    input  logic [7:0]                        i_port_value,
    input  logic [pbm_pkg::ADDR_W-1:0]        i_cpu_address,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pbm_pkg::PHYS_W-1:0]        o_physical_address,
    output logic                              o_unavailable,
    output logic                              o_locked,
    output logic                              o_write_protect,
    // configuration
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [pbm_pkg::CFG_W-1:0]         i_cfg_data
);
    import pbm_pkg::*;

    localparam int FRAME_W = $clog2(VIRTUAL_KB);

    logic [TABLE_ENTRIES-1:0] r_lock_mask;
    logic [TABLE_ENTRIES-1:0] r_rom_mask;

    logic                     r_valid, n_valid;
    logic [PHYS_W-1:0]        r_phys;
    logic                     r_unav;
    logic                     r_locked;
    logic                     r_wprot;

    t_ctrl_sts                sts;
    t_tbl_wr                  wr;
    logic [FRAME_W-1:0]       wr_frame;
    logic                     rd_en;
    logic [ENTRY_W-1:0]       rd_entry;
    logic [FRAME_W-1:0]       rd_frame;
    logic                     rd_unav;
    logic                     out_free;

    logic [ENTRY_W-1:0]           res_entry;
    logic [FRAME_W+PAGE_OFS_W-1:0] res_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_mask <= '0;
            r_rom_mask  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOCK_MASK: r_lock_mask <= i_cfg_data;
                CFG_ROM_MASK:  r_rom_mask  <= i_cfg_data;
                default:       r_lock_mask <= r_lock_mask;
            endcase
        end
    end

    assign out_free = !r_valid || !i_stall;

    pbm_ctrl #(
        .VIRTUAL_KB (VIRTUAL_KB)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_command     (i_command),
        .i_port_value  (i_port_value),
        .i_cpu_address (i_cpu_address),
        .i_lock_mask   (r_lock_mask),
        .i_out_free    (out_free),
        .o_sts         (sts),
        .o_wr          (wr),
        .o_wr_frame    (wr_frame),
        .o_rd_en       (rd_en),
        .o_rd_entry    (rd_entry)
    );

    pbm_table #(
        .FRAME_W (FRAME_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_wr_frame (wr_frame),
        .i_rd_en    (rd_en),
        .i_rd_entry (rd_entry),
        .o_rd_frame (rd_frame),
        .o_rd_unav  (rd_unav)
    );

    // result word from the registered table read
    assign res_entry = sts.addr[ADDR_W-1:PAGE_OFS_W];
    assign res_full  = {rd_frame, sts.addr[PAGE_OFS_W-1:0]};

    // output register valid
    always_comb begin
        n_valid = r_valid;
        if (sts.res_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (sts.res_load) begin
            r_phys   <= rd_unav ? '0 : PHYS_W'(res_full);
            r_unav   <= rd_unav;
            r_locked <= r_lock_mask[res_entry];
            r_wprot  <= r_rom_mask[res_entry] | rd_unav;
        end
    end

    assign o_stall            = !sts.ready;
    assign o_valid            = r_valid;
    assign o_physical_address = r_phys;
    assign o_unavailable      = r_unav;
    assign o_locked           = r_locked;
    assign o_write_protect    = r_wprot;

endmodule

// File: design/pbm_checker.sv
module pbm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [1:0]                  i_command,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [pbm_pkg::PHYS_W-1:0]  o_physical_address,
    input logic                        o_unavailable,
    input logic                        o_write_protect
);
    import pbm_pkg::*;

    // a held result word keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_physical_address))
        else $error("result word changed while stalled");

    // an unavailable page gives a zero address and is write protected
    a_unav_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unavailable |-> (o_physical_address == '0) && o_write_protect)
        else $error("unavailable page with address or without write protect");

    // every real command that is taken makes the block busy and raise o_stall
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && ((i_command == CMD_PORT_WRITE) ||
        (i_command == CMD_LOOKUP) || (i_command == CMD_RESET_PAGES)) |=> o_stall)
        else $error("block took a new word right after a command");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

endmodule

bind paged_ram_bank_mapper pbm_checker u_pbm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .i_command          (i_command),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_physical_address (o_physical_address),
    .o_unavailable      (o_unavailable),
    .o_write_protect    (o_write_protect)
);
